/* rtl/core/event_interval_stats_monitor_defines.svh */
// Assertion macros shared by the event interval statistics monitor RTL.
`ifndef EVENT_INTERVAL_STATS_MONITOR_DEFINES_SVH
`define EVENT_INTERVAL_STATS_MONITOR_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, reset-qualified.
`define EISM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("eism assertion failed");
// Next-cycle implication, reset-qualified.
`define EISM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("eism assertion failed");
`else
`define EISM_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define EISM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/eism_pkg.sv */
// Package: opcodes and controller states of the event interval statistics monitor.
`timescale 1ns / 1ps
package eism_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_INC   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ST,
		S_QRD,
		S_QACC,
		S_ABS,
		S_DIV,
		S_FIN,
		S_EMIT
	} state_t;

endpackage

/* rtl/core/event_interval_stats_monitor.sv */
// Top level: per-channel event interval monitor with duration history and statistics.
// Usage:
//   Input beat (in_valid/in_ready): op, channel, timestamp. Start latches the time,
//   end stores the elapsed time in the channel's history ring and counts the event,
//   increment does end then start and returns the count, query returns sample count,
//   truncated average, minimum and maximum of the history plus the event count.
//   Output beat (out_valid/out_ready): one result for increment and query only.
//   An out-of-range channel changes nothing; increment/query then return zeros.
// Timing (one item in flight; per-channel state sits in a memory with a registered read):
//   start/end: state read, then write back.
//   increment: state read, write back, then the output register; then the next beat.
//   query: state read, then the history walk, absolute value step, divider, sign
//   restore and output register; an empty history goes from the state read to the
//   output register. The history walk takes one ring read and one accumulate per
//   sample, and the average comes from a bit-serial divider, one quotient bit per cycle.
// Reset clears all channel state through per-channel valid bits; no clearing pass.
// A result waits in the output register while the next beat is accepted; if the
// receiver still stalls when the following result is ready, the block waits.
`timescale 1ns / 1ps
module event_interval_stats_monitor #(
	parameter int CHANNELS      = 16,
	parameter int HISTORY_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  channel,
	input  logic [62:0] timestamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_query,
	output logic [63:0] event_count,
	output logic [3:0]  sample_count,
	output logic signed [63:0] average,
	output logic signed [63:0] minimum,
	output logic signed [63:0] maximum
);
	import eism_pkg::*;

`include "event_interval_stats_monitor_defines.svh"

	localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW   = $clog2(HISTORY_DEPTH);
	localparam int RAW  = $clog2(CHANNELS * HISTORY_DEPTH);
	localparam int SUMW = 64 + IW;
	localparam int DCW  = $clog2(SUMW + 1);

	typedef struct packed {
		logic [63:0]   start;
		logic [63:0]   events;
		logic [IW-1:0] widx;
		logic [IW-1:0] oidx;
	} chan_state_t;

	// Memories
	chan_state_t   st_mem [CHANNELS];
	logic [63:0]   ring_mem [CHANNELS * HISTORY_DEPTH];
	chan_state_t   st_rd_s1;
	logic          st_vld_s1;
	logic [63:0]   ring_rd_s1;
	logic [CHANNELS-1:0] st_valid_q;

	// Control and datapath registers
	state_t        state_q, state_d;
	op_t           op_q;
	logic [3:0]    ch_q;
	logic [62:0]   ts_q;
	logic [IW-1:0] pos_q, cnt_q, n_q;
	logic [SUMW-1:0] sum_q, dvd_q;
	logic [IW:0]   rem_q;
	logic [DCW-1:0] dcnt_q;
	logic          neg_q;
	logic signed [63:0] min_q, max_q;
	logic          res_query_q;
	logic [63:0]   res_events_q;
	logic [IW-1:0] res_n_q;
	logic [63:0]   res_avg_q;
	logic          out_valid_q;

	// Combinational signals
	logic          accept;
	logic          in_ok;
	logic          ch_ok;
	logic [CW-1:0] st_raddr, ch_idx;
	chan_state_t   cur, st_wdata;
	logic          st_we;
	logic [63:0]   dur;
	logic [IW-1:0] w_nx, o_nx, n_cur;
	logic [63:0]   ev_nx;
	logic [RAW-1:0] ring_base, ring_waddr, ring_raddr;
	logic          ring_we;
	logic [SUMW-1:0] v_ext, sum_nx, q_signed;
	logic [IW:0]   rem_sh;
	logic          ge;
	logic          emit_go;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_ok    = (32'(channel) < CHANNELS);
	assign st_raddr = in_ok ? CW'(channel) : '0;
	assign ch_ok    = (32'(ch_q) < CHANNELS);
	assign ch_idx   = CW'(ch_q);
	assign cur      = st_vld_s1 ? st_rd_s1 : '0;

	// Channel state update terms
	assign dur   = {1'b0, ts_q} - cur.start;
	assign w_nx  = (32'(cur.widx) == HISTORY_DEPTH - 1) ? '0 : cur.widx + 1'b1;
	assign o_nx  = (32'(cur.oidx) == HISTORY_DEPTH - 1) ? '0 : cur.oidx + 1'b1;
	assign ev_nx = cur.events + 64'd1;
	assign n_cur = (cur.widx >= cur.oidx) ? (cur.widx - cur.oidx) :
		IW'((IW + 1)'(cur.widx) + (IW + 1)'(HISTORY_DEPTH) - (IW + 1)'(cur.oidx));

	// Ring addressing
	assign ring_base  = RAW'(RAW'(ch_idx) * RAW'(HISTORY_DEPTH));
	assign ring_waddr = ring_base + RAW'(cur.widx);
	assign ring_raddr = ring_base + RAW'(pos_q);

	// Walk and divide terms
	assign v_ext    = {{IW{ring_rd_s1[63]}}, ring_rd_s1};
	assign sum_nx   = sum_q + v_ext;
	assign rem_sh   = {rem_q[IW-1:0], dvd_q[SUMW-1]};
	assign ge       = (rem_sh >= {1'b0, n_q});
	assign q_signed = neg_q ? ('0 - dvd_q) : dvd_q;
	assign emit_go  = !out_valid_q || out_ready;

	// Next state and memory write controls
	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_wdata = cur;
		ring_we  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_ST;
			end
			S_ST: begin
				if (!ch_ok) begin
					state_d = (op_q == OP_INC || op_q == OP_QUERY) ? S_EMIT : S_IDLE;
				end else begin
					case (op_q)
						OP_START: begin
							st_we = 1'b1;
							st_wdata.start = {1'b0, ts_q};
							state_d = S_IDLE;
						end
						OP_END, OP_INC: begin
							st_we = 1'b1;
							ring_we = 1'b1;
							st_wdata.widx = w_nx;
							st_wdata.oidx = (w_nx == cur.oidx) ? o_nx : cur.oidx;
							st_wdata.events = ev_nx;
							if (op_q == OP_INC) st_wdata.start = {1'b0, ts_q};
							state_d = (op_q == OP_INC) ? S_EMIT : S_IDLE;
						end
						default: begin
							state_d = (n_cur == '0) ? S_EMIT : S_QRD;
						end
					endcase
				end
			end
			S_QRD: state_d = S_QACC;
			S_QACC: state_d = (cnt_q == n_q - 1'b1) ? S_ABS : S_QRD;
			S_ABS: state_d = S_DIV;
			S_DIV: begin
				if (32'(dcnt_q) == SUMW - 1) state_d = S_FIN;
			end
			S_FIN: state_d = S_EMIT;
			S_EMIT: begin
				if (emit_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Channel state memory, registered read
	always_ff @(posedge clk) begin
		if (st_we) st_mem[ch_idx] <= st_wdata;
		st_rd_s1 <= st_mem[st_raddr];
	end

	// Duration ring memory, registered read
	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_waddr] <= dur;
		ring_rd_s1 <= ring_mem[ring_raddr];
	end

	// Valid bits stand in for the reset of the channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q <= '0;
			st_vld_s1  <= 1'b0;
		end else begin
			if (st_we) st_valid_q[ch_idx] <= 1'b1;
			st_vld_s1 <= st_valid_q[st_raddr];
		end
	end

	// Item, walk and divider registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= op_t'(op);
					ch_q <= channel;
					ts_q <= timestamp;
				end
			end
			S_ST: begin
				res_query_q  <= (op_q == OP_QUERY);
				res_events_q <= '0;
				res_n_q      <= '0;
				res_avg_q    <= '0;
				min_q        <= '0;
				max_q        <= '0;
				pos_q        <= cur.oidx;
				cnt_q        <= '0;
				n_q          <= n_cur;
				sum_q        <= '0;
				if (ch_ok) begin
					if (op_q == OP_INC) res_events_q <= ev_nx;
					if (op_q == OP_QUERY) begin
						res_events_q <= cur.events;
						res_n_q      <= n_cur;
					end
				end
			end
			S_QRD: begin
				pos_q <= (32'(pos_q) == HISTORY_DEPTH - 1) ? '0 : pos_q + 1'b1;
			end
			S_QACC: begin
				sum_q <= sum_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '0 || $signed(ring_rd_s1) < min_q) min_q <= ring_rd_s1;
				if (cnt_q == '0 || $signed(ring_rd_s1) > max_q) max_q <= ring_rd_s1;
			end
			S_ABS: begin
				neg_q  <= sum_q[SUMW-1];
				dvd_q  <= sum_q[SUMW-1] ? ('0 - sum_q) : sum_q;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				rem_q  <= ge ? (rem_sh - {1'b0, n_q}) : rem_sh;
				dvd_q  <= {dvd_q[SUMW-2:0], ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_FIN: res_avg_q <= q_signed[63:0];
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == S_EMIT && emit_go) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_go) begin
			is_query     <= res_query_q;
			event_count  <= res_events_q;
			sample_count <= 4'(res_n_q);
			average      <= res_avg_q;
			minimum      <= min_q;
			maximum      <= max_q;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	`EISM_ASSERT_NEXT(a_accept_reads, clk, arst_n, accept, state_q == S_ST)
	`EISM_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == S_QACC, cnt_q < n_q)
	`EISM_ASSERT_IMPL(a_ptr_range, clk, arst_n, state_q == S_ST && ch_ok, (32'(cur.widx) < HISTORY_DEPTH) && (32'(cur.oidx) < HISTORY_DEPTH))
	`EISM_ASSERT_IMPL(a_emit_op, clk, arst_n, state_q == S_EMIT, op_q == OP_INC || op_q == OP_QUERY)

endmodule
